// ----- hdl/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
package spq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int PRIO_BITS     = 8;
   localparam int VALUE_BITS    = 32;
   localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(QUEUE_DEPTH);

   typedef struct packed {
      logic                  valid;
      logic [VALUE_BITS-1:0] value;
      logic [PRIO_BITS-1:0]  prio;
   } entry_type;

   typedef struct packed {
      logic                  insert;
      logic                  pop;
      logic [VALUE_BITS-1:0] value;
      logic [PRIO_BITS-1:0]  prio;
   } cmd_type;

endpackage

// ----- hdl/spq_cell.sv -----
// one slot of the sorted chain: holds an entry and trades it with its neighbors
module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  entry_type prev_entry,
   input  logic      prev_keep,
   input  entry_type next_entry,
   output entry_type entry,
   output logic      keep
);

   logic                  valid_ff, valid_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [PRIO_BITS-1:0]  prio_ff, prio_in;

   // entry stays put when it outranks or ties the new item
   assign keep = valid_ff && (prio_ff >= cmd.prio);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      prio_in  = prio_ff;
      if (cmd.insert) begin
         if (!keep) begin
            if (prev_keep) begin
               valid_in = 1'b1;
               value_in = cmd.value;
               prio_in  = cmd.prio;
            end else begin
               valid_in = prev_entry.valid;
               value_in = prev_entry.value;
               prio_in  = prev_entry.prio;
            end
         end
      end else if (cmd.pop) begin
         valid_in = next_entry.valid;
         value_in = next_entry.value;
         prio_in  = next_entry.prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign entry.valid = valid_ff;
   assign entry.value = value_ff;
   assign entry.prio  = prio_ff;

endmodule

// ----- hdl/sorted_priority_queue_core.sv -----
// top level of the sorted priority queue: cell chain, counter and result register
//
// usage
//   - an item is taken at a rising edge where start is high and busy is low;
//     req_opcode picks insert, pop or peek (unused code acts as a peek)
//   - every item gives exactly one result, shown for one cycle with rsp_valid
//     high in the cycle right after the item was taken
//   - latency is one cycle and one item may be taken every cycle: each cell
//     of the chain decides from its own compare and its neighbors alone
//   - the receiver cannot stall, so a result that is not taken is gone
//   - busy is high during reset and in the first cycle after it; the cells'
//     valid bits and the entry count clear at reset, payload is left alone
//   - result shows the queue after the item: head entry (zero if empty),
//     empty flag, count and status (ok, pop on empty, insert refused full)
//   - equal priorities leave in arrival order: a new item lands behind every
//     entry whose priority is greater or equal
module sorted_priority_queue_core
   import spq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic signed [31:0]    req_item_value,
   input  logic [7:0]            req_item_priority,
   output logic                  rsp_valid,
   output logic signed [31:0]    rsp_head_value,
   output logic [7:0]            rsp_head_priority,
   output logic                  rsp_queue_empty,
   output logic [4:0]            rsp_entry_count,
   output logic [1:0]            rsp_status
);

   logic                  busy_ff;
   logic                  rsp_valid_ff;
   logic [1:0]            status_ff, status_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic      accept;
   logic      is_full;
   logic      is_empty;
   cmd_type   cmd;
   entry_type entries [QUEUE_DEPTH];
   logic      keeps   [QUEUE_DEPTH];

   assign accept   = start && !busy_ff;
   assign is_full  = (count_ff == COUNT_FULL);
   assign is_empty = (count_ff == '0);

   // command broadcast to every cell; refused operations become no-ops
   always_comb begin
      cmd.insert = accept && (req_opcode == OP_INSERT) && !is_full;
      cmd.pop    = accept && (req_opcode == OP_POP) && !is_empty;
      cmd.value  = req_item_value;
      cmd.prio   = req_item_priority[PRIO_BITS-1:0];
   end

   // status and count for the result
   always_comb begin
      status_in = ST_OK;
      count_in  = count_ff;
      case (req_opcode)
         OP_INSERT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // chain of cells, slot 0 is the head
   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         entry_type prev_e;
         entry_type next_e;
         logic      prev_k;

         if (gi == 0) begin : g_first
            // nothing ranks ahead of the head, so the boundary always keeps
            assign prev_e = '0;
            assign prev_k = 1'b1;
         end else begin : g_mid
            assign prev_e = entries[gi-1];
            assign prev_k = keeps[gi-1];
         end

         if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign next_e = '0;
         end else begin : g_body
            assign next_e = entries[gi+1];
         end

         spq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .prev_entry (prev_e),
            .prev_keep  (prev_k),
            .next_entry (next_e),
            .entry      (entries[gi]),
            .keep       (keeps[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      if (accept) begin
         status_ff <= status_in;
      end
   end

   // head fields come straight from slot 0, which already holds the new state
   assign busy              = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_head_value    = entries[0].valid ? entries[0].value : '0;
   assign rsp_head_priority = entries[0].valid ? entries[0].prio : '0;
   assign rsp_queue_empty   = (count_ff == '0);
   assign rsp_entry_count   = count_ff;
   assign rsp_status        = status_ff;

endmodule

// ----- hdl/spq_checker.sv -----
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker
   import spq_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic signed [31:0]  rsp_head_value,
   input logic [7:0]          rsp_head_priority,
   input logic                rsp_queue_empty,
   input logic [4:0]          rsp_entry_count,
   input logic [1:0]          rsp_status
);

   // one result for each item, in the cycle after it is taken
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("item taken without a result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result without an item");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_queue_empty == (rsp_entry_count == 5'd0)))
      else $error("empty flag disagrees with count");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_queue_empty) |-> (rsp_head_value == 32'sd0 &&
                                          rsp_head_priority == 8'd0))
      else $error("empty queue shows a head");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_entry_count == COUNT_FULL))
      else $error("insert refused while not full");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_head_value    (rsp_head_value),
   .rsp_head_priority (rsp_head_priority),
   .rsp_queue_empty   (rsp_queue_empty),
   .rsp_entry_count   (rsp_entry_count),
   .rsp_status        (rsp_status)
);
